// File: rtl/wildcard_byte_pattern_scanner_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wildcard byte pattern scanner
// Shared property forms, sampled on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_UNIT_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define WBPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WBPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Constants and types shared by the wildcard byte pattern scanner files.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int MaxPattern = 8;
  localparam int ByteW      = 8;
  localparam int PatternW   = MaxPattern * ByteW;
  localparam int MaskW      = MaxPattern;
  localparam int LenW       = 4;
  localparam int AddrW      = 48;
  localparam int IdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegPattern = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMask    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLength  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBase    = 2'd3;

  // Shift control handed to every cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // What one cell compares against.
  typedef struct packed {
    logic [ByteW-1:0] pat;
    logic             wild;
    logic             in_use;
  } cell_cfg_t;

  // Effective pattern length: zero reads as one, large values saturate.
  function automatic logic [LenW-1:0] used_len(input logic [LenW-1:0] len);
    logic [LenW-1:0] res;
    res = len;
    if (len == '0) begin
      res = LenW'(1);
    end else if (len > LenW'(MaxPattern)) begin
      res = LenW'(MaxPattern);
    end
    return res;
  endfunction

endpackage

// File: rtl/wbps_in_if.sv
// ----------------------------------------------------------------------------
// wbps_in_if
// Byte input channel: one memory byte and its end-of-range flag per item.
// ----------------------------------------------------------------------------
interface wbps_in_if;
  logic                       valid;
  logic                       ready;
  logic [wbps_pkg::ByteW-1:0] data_byte;
  logic                       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: rtl/wbps_out_if.sv
// ----------------------------------------------------------------------------
// wbps_out_if
// Result channel: found flag and start address of the match.
// ----------------------------------------------------------------------------
interface wbps_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [wbps_pkg::AddrW-1:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink (input valid, input found, input match_address, output ready);
endinterface

// File: rtl/wildcard_byte_pattern_scanner_unit.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner_unit
// Searches a byte stream for a pattern with wildcard positions.
// ----------------------------------------------------------------------------
// Usage: bytes arrive on byte_i in ascending address order, one item per
// byte; last_byte marks the end of a scanned range. The first window that
// matches the pattern gives one item on result_o with found set and the
// address of the first matched byte. A range that ends without a match
// gives one item with found clear and address zero; later bytes of a
// range that already matched give nothing.
// Throughput is one byte per cycle unless a stalled result holds the
// input back. The window is a row of cells that shift on every accepted
// byte; each cell compares its incoming byte in parallel, so a result is
// loaded into the output register at the edge that accepts its byte.
// The output register decouples the sides: byte_i stays ready while the
// register is empty or being drained, so a result that the receiver
// stalls holds the input back until it is taken.
// Reset empties the window, clears the output register and loads the
// register file with its defaults (pattern length one). Configuration must be
// written through cfg_we_i only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scanner_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wbps_pkg::CfgDataW-1:0] cfg_wdata_i,
  wbps_in_if.sink                       byte_i,
  wbps_out_if.source                    result_o
);

  localparam int NCells = wbps_pkg::MaxPattern;

  // Configuration registers.
  logic [wbps_pkg::PatternW-1:0] pattern_q;
  logic [wbps_pkg::MaskW-1:0]    mask_q;
  logic [wbps_pkg::LenW-1:0]     length_q;
  logic [wbps_pkg::AddrW-1:0]    base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      mask_q    <= '0;
      length_q  <= wbps_pkg::LenW'(1);
      base_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wbps_pkg::RegPattern: pattern_q <= cfg_wdata_i[wbps_pkg::PatternW-1:0];
        wbps_pkg::RegMask:    mask_q    <= cfg_wdata_i[wbps_pkg::MaskW-1:0];
        wbps_pkg::RegLength:  length_q  <= cfg_wdata_i[wbps_pkg::LenW-1:0];
        wbps_pkg::RegBase:    base_q    <= cfg_wdata_i[wbps_pkg::AddrW-1:0];
        default: ;
      endcase
    end
  end

  logic [wbps_pkg::LenW-1:0] len;
  assign len = wbps_pkg::used_len(length_q);

  // Handshake: the input is taken whenever the output register can
  // accept a new result in the same edge.
  logic out_valid_q;
  logic accept;
  assign byte_i.ready = !out_valid_q || result_o.ready;
  assign accept       = byte_i.valid && byte_i.ready;

  wbps_pkg::cell_ctrl_t ctrl;
  assign ctrl.shift = accept;
  assign ctrl.clear = byte_i.last_byte;

  // The cell row. Cell 0 takes the newest byte; cell a, counted as age a,
  // is compared with pattern byte len-1-a.
  logic [wbps_pkg::ByteW-1:0] cell_byte [NCells];
  logic                       cell_valid[NCells];
  logic [NCells-1:0]          cell_hit;

  for (genvar a = 0; a < NCells; a++) begin : g_cell
    wbps_pkg::cell_cfg_t        ccfg;
    logic [wbps_pkg::LenW-1:0]  pidx;
    logic [wbps_pkg::ByteW-1:0] prev_byte;
    logic                       prev_valid;

    assign pidx        = len - wbps_pkg::LenW'(1) - wbps_pkg::LenW'(a);
    assign ccfg.pat    = pattern_q[pidx[wbps_pkg::IdxW-1:0] * wbps_pkg::ByteW +:
                                   wbps_pkg::ByteW];
    assign ccfg.wild   = mask_q[pidx[wbps_pkg::IdxW-1:0]];
    assign ccfg.in_use = wbps_pkg::LenW'(a) < len;

    if (a == 0) begin : g_head
      assign prev_byte  = byte_i.data_byte;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_byte  = cell_byte[a-1];
      assign prev_valid = cell_valid[a-1];
    end

    wbps_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cfg_i        (ccfg),
      .prev_byte_i  (prev_byte),
      .prev_valid_i (prev_valid),
      .byte_o       (cell_byte[a]),
      .valid_o      (cell_valid[a]),
      .hit_o        (cell_hit[a])
    );
  end

  // Scan bookkeeping. An empty window means this byte opens a scan and
  // takes its address from the base register.
  logic                       match_done_q, match_done_d;
  logic [wbps_pkg::AddrW-1:0] addr_q, addr_d;
  logic [wbps_pkg::AddrW-1:0] cur_addr;
  logic [wbps_pkg::AddrW-1:0] start_addr;
  logic                       match;

  assign cur_addr   = cell_valid[0] ? addr_q : base_q;
  assign match      = !match_done_q && (&cell_hit);
  assign start_addr = cur_addr - wbps_pkg::AddrW'(len - wbps_pkg::LenW'(1));

  always_comb begin
    match_done_d = match_done_q;
    addr_d       = addr_q;
    if (accept) begin
      if (byte_i.last_byte) begin
        match_done_d = 1'b0;
        addr_d       = base_q;
      end else begin
        match_done_d = match_done_q || match;
        addr_d       = cur_addr + wbps_pkg::AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_done_q <= 1'b0;
      addr_q       <= '0;
    end else begin
      match_done_q <= match_done_d;
      addr_q       <= addr_d;
    end
  end

  // Output register.
  logic                       res_emit;
  logic                       found_q;
  logic [wbps_pkg::AddrW-1:0] res_addr_q;
  logic                       out_valid_d;

  assign res_emit = accept && (match || (byte_i.last_byte && !match_done_q));

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_emit) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_emit) begin
      found_q    <= match;
      res_addr_q <= match ? start_addr : '0;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.found         = found_q;
  assign result_o.match_address = res_addr_q;

endmodule

// File: rtl/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell
// One window position: holds a byte and its valid bit, compares the byte
// that is shifting in against the pattern byte for this position.
// ----------------------------------------------------------------------------
module wbps_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wbps_pkg::cell_ctrl_t       ctrl_i,
  input  wbps_pkg::cell_cfg_t        cfg_i,
  input  logic [wbps_pkg::ByteW-1:0] prev_byte_i,
  input  logic                       prev_valid_i,
  output logic [wbps_pkg::ByteW-1:0] byte_o,
  output logic                       valid_o,
  output logic                       hit_o
);

  logic [wbps_pkg::ByteW-1:0] byte_q;
  logic                       valid_q, valid_d;

  // Judged on the byte this cell will hold after the shift.
  assign hit_o = !cfg_i.in_use ||
                 (prev_valid_i && (cfg_i.wild || (prev_byte_i == cfg_i.pat)));

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      valid_d = ctrl_i.clear ? 1'b0 : prev_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= prev_byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

// File: rtl/wbps_checker.sv
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks for the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scanner_unit_assert.svh"

module wbps_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       found_i,
  input logic [wbps_pkg::AddrW-1:0] match_address_i
);

  // A stalled result must not change.
  `WBPS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(found_i) && $stable(match_address_i), "result changed while stalled")

  // A miss always reports address zero.
  `WBPS_ASSERT_NOW(a_miss_addr, out_valid_i && !found_i, match_address_i == '0, "miss with nonzero address")

  // An empty output register never holds the input back.
  `WBPS_ASSERT_NOW(a_in_ready, !out_valid_i, in_ready_i, "input stalled with empty output")

  // A new result only follows an accepted byte.
  `WBPS_ASSERT_NOW(a_out_cause, $rose(out_valid_i), $past(in_valid_i && in_ready_i), "result without an accepted byte")

endmodule

bind wildcard_byte_pattern_scanner_unit wbps_checker u_wbps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (byte_i.valid),
  .in_ready_i      (byte_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .found_i         (result_o.found),
  .match_address_i (result_o.match_address)
);
